// ----- rtl/dtip_pkg.sv -----
// Package for the dual timer and interrupt port unit.
// Holds the item kinds, the register map and the item and result types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dtip_pkg;

  // Kind of one input item.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_PEEK  = 2'd2,
    OP_TICK  = 2'd3
  } op_e;

  // Register map.
  localparam logic [3:0] REG_PORT_A  = 4'd0;
  localparam logic [3:0] REG_PORT_B  = 4'd1;
  localparam logic [3:0] REG_DIR_A   = 4'd2;
  localparam logic [3:0] REG_DIR_B   = 4'd3;
  localparam logic [3:0] REG_TA_LO   = 4'd4;
  localparam logic [3:0] REG_TA_HI   = 4'd5;
  localparam logic [3:0] REG_TB_LO   = 4'd6;
  localparam logic [3:0] REG_TB_HI   = 4'd7;
  localparam logic [3:0] REG_ICR     = 4'd13;
  localparam logic [3:0] REG_CTRL_A  = 4'd14;
  localparam logic [3:0] REG_CTRL_B  = 4'd15;

  // Bit positions in the control and flag registers.
  localparam int unsigned CtrlRunBit     = 0;
  localparam int unsigned CtrlOneShotBit = 3;
  localparam int unsigned FlagSumBit     = 7;

  // One input item.
  typedef struct packed {
    op_e        op;
    logic [3:0] reg_req;
    logic [7:0] wdata;
    logic [7:0] port_b_in;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] rdata;
    logic       irq;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/dtip_core.sv -----
// Register file, timers and interrupt logic of the dual timer port unit.
// Updates state for one item per fire strobe and gives its result.
// Depends on dtip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtip_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire dtip_pkg::item_t  item_i,
  output dtip_pkg::result_t     result_o
);
  import dtip_pkg::*;

  logic [7:0]  port_a_q, port_a_d;
  logic [7:0]  dir_a_q, dir_a_d;
  logic [7:0]  dir_b_q, dir_b_d;
  logic [15:0] latch_a_q, latch_a_d;
  logic [15:0] latch_b_q, latch_b_d;
  logic [15:0] count_a_q, count_a_d;
  logic [15:0] count_b_q, count_b_d;
  logic [6:0]  mask_q, mask_d;
  logic [7:0]  flags_q, flags_d;
  logic [7:0]  ctrl_a_q, ctrl_a_d;
  logic [7:0]  ctrl_b_q, ctrl_b_d;
  logic        irq_q, irq_d;
  logic [7:0]  rdata;

  // Next state and read data for the current item. Port B writes have no
  // visible effect, since reads of port B return the external input.
  always_comb begin
    port_a_d  = port_a_q;
    dir_a_d   = dir_a_q;
    dir_b_d   = dir_b_q;
    latch_a_d = latch_a_q;
    latch_b_d = latch_b_q;
    count_a_d = count_a_q;
    count_b_d = count_b_q;
    mask_d    = mask_q;
    flags_d   = flags_q;
    ctrl_a_d  = ctrl_a_q;
    ctrl_b_d  = ctrl_b_q;
    irq_d     = irq_q;
    rdata     = 8'd0;
    case (item_i.op)
      OP_WRITE: begin
        case (item_i.reg_req)
          REG_PORT_A: port_a_d = item_i.wdata;
          REG_DIR_A:  dir_a_d  = item_i.wdata;
          REG_DIR_B:  dir_b_d  = item_i.wdata;
          REG_TA_LO:  latch_a_d[7:0]  = item_i.wdata;
          REG_TA_HI:  latch_a_d[15:8] = item_i.wdata;
          REG_TB_LO:  latch_b_d[7:0]  = item_i.wdata;
          REG_TB_HI:  latch_b_d[15:8] = item_i.wdata;
          REG_ICR: begin
            if (item_i.wdata[7]) begin
              mask_d = mask_q | item_i.wdata[6:0];
            end else begin
              mask_d = mask_q & ~item_i.wdata[6:0];
            end
          end
          REG_CTRL_A: begin
            if (item_i.wdata[CtrlRunBit] && !ctrl_a_q[CtrlRunBit]) begin
              count_a_d = latch_a_q;
            end
            ctrl_a_d = item_i.wdata;
          end
          REG_CTRL_B: begin
            if (item_i.wdata[CtrlRunBit] && !ctrl_b_q[CtrlRunBit]) begin
              count_b_d = latch_b_q;
            end
            ctrl_b_d = item_i.wdata;
          end
          default: begin
          end
        endcase
      end
      OP_READ, OP_PEEK: begin
        case (item_i.reg_req)
          REG_PORT_A: rdata = port_a_q;
          REG_PORT_B: rdata = item_i.port_b_in;
          REG_DIR_A:  rdata = dir_a_q;
          REG_DIR_B:  rdata = dir_b_q;
          REG_TA_LO:  rdata = count_a_q[7:0];
          REG_TA_HI:  rdata = count_a_q[15:8];
          REG_TB_LO:  rdata = count_b_q[7:0];
          REG_TB_HI:  rdata = count_b_q[15:8];
          REG_ICR: begin
            rdata = flags_q;
            if (flags_q[FlagSumBit]) begin
              irq_d = 1'b0;
            end
            if (item_i.op == OP_READ) begin
              flags_d = 8'd0;
            end
          end
          REG_CTRL_A: rdata = ctrl_a_q;
          REG_CTRL_B: rdata = ctrl_b_q;
          default:    rdata = 8'd0;
        endcase
      end
      OP_TICK: begin
        // Timer A counts down, reloads and flags at expiry, and stops there in one-shot mode.
        if (ctrl_a_q[CtrlRunBit]) begin
          if (count_a_q <= 16'd1) begin
            count_a_d  = latch_a_q;
            flags_d[0] = 1'b1;
            if (ctrl_a_q[CtrlOneShotBit]) begin
              ctrl_a_d[CtrlRunBit] = 1'b0;
            end
          end else begin
            count_a_d = count_a_q - 16'd1;
          end
        end
        // Timer B, same scheme.
        if (ctrl_b_q[CtrlRunBit]) begin
          if (count_b_q <= 16'd1) begin
            count_b_d  = latch_b_q;
            flags_d[1] = 1'b1;
            if (ctrl_b_q[CtrlOneShotBit]) begin
              ctrl_b_d[CtrlRunBit] = 1'b0;
            end
          end else begin
            count_b_d = count_b_q - 16'd1;
          end
        end
        // While the summary bit is clear, an enabled flag sets it and raises the line.
        if (!flags_d[FlagSumBit] && ((flags_d[6:0] & mask_q) != 7'd0)) begin
          flags_d[FlagSumBit] = 1'b1;
          irq_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // State registers, updated once per accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_a_q  <= 8'd0;
      dir_a_q   <= 8'd0;
      dir_b_q   <= 8'd0;
      latch_a_q <= 16'd0;
      latch_b_q <= 16'd0;
      count_a_q <= 16'd0;
      count_b_q <= 16'd0;
      mask_q    <= 7'd0;
      flags_q   <= 8'd0;
      ctrl_a_q  <= 8'd0;
      ctrl_b_q  <= 8'd0;
      irq_q     <= 1'b0;
    end else if (fire_i) begin
      port_a_q  <= port_a_d;
      dir_a_q   <= dir_a_d;
      dir_b_q   <= dir_b_d;
      latch_a_q <= latch_a_d;
      latch_b_q <= latch_b_d;
      count_a_q <= count_a_d;
      count_b_q <= count_b_d;
      mask_q    <= mask_d;
      flags_q   <= flags_d;
      ctrl_a_q  <= ctrl_a_d;
      ctrl_b_q  <= ctrl_b_d;
      irq_q     <= irq_d;
    end
  end

  assign result_o.rdata = rdata;
  assign result_o.irq   = irq_d;

`ifndef NO_ASSERTIONS
  // The line is only ever high while the summary bit is set.
  a_irq_has_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    irq_q |-> flags_q[FlagSumBit])
    else $error("interrupt line high without summary flag");

  // A peek never changes the flags.
  a_peek_keeps_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.op == OP_PEEK) |=> $stable(flags_q))
    else $error("peek changed the interrupt flags");

  // A stopped timer A holds its count across a tick.
  a_stopped_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.op == OP_TICK && !ctrl_a_q[CtrlRunBit]) |=> $stable(count_a_q))
    else $error("stopped timer A counted");
`endif

endmodule

`default_nettype wire

// ----- rtl/dual_timer_interrupt_port_unit.sv -----
// Top level of the dual timer and interrupt port unit.
// Input and output stream stages around dtip_core. Depends on dtip_pkg.
//
// Usage:
//   The slave channel takes one item per handshake: tuser carries the kind
//   (write, read, peek or timer tick), tdata the register index, write
//   byte and port B input value. The master channel returns exactly one
//   result item per input item, in order: the read byte (zero for writes
//   and ticks) and the interrupt line level after that item.
//   Flow: an accepted item is registered in the input stage, processed by
//   the core as it moves on, and its result is registered in the output
//   register and valid on the master channel. Throughput is one item per
//   cycle while the receiver keeps up; the input stage and the output
//   register each hold one item so both sides run back to back.
//   Reset clears all timers, latches, ports, mask, flags and the line, and
//   empties both stages. When the receiver stalls, the result holds in the
//   output register, one more item waits in the input stage, and then
//   s_axis_tready_o drops until the receiver takes the result.
`timescale 1ns / 1ps
`default_nettype none

module dual_timer_interrupt_port_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // tdata: reg_req [3:0], wdata [11:4], port_b_in [19:12], zero [23:20]
  input  wire logic [23:0] s_axis_tdata_i,
  // tuser: op [1:0]
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // tdata: rdata [7:0], irq [8], zero [15:9]
  output logic [15:0]      m_axis_tdata_o
);
  import dtip_pkg::*;

  logic    in_valid_q;
  item_t   in_item_q;
  logic    out_valid_q;
  result_t out_q;
  result_t result;
  logic    advance;
  logic    s_fire;

  // The input stage moves on whenever the output register is free or drains.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  // Input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_item_q.op        <= op_e'(s_axis_tuser_i);
      in_item_q.reg_req   <= s_axis_tdata_i[3:0];
      in_item_q.wdata     <= s_axis_tdata_i[11:4];
      in_item_q.port_b_in <= s_axis_tdata_i[19:12];
    end
  end

  dtip_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (in_item_q),
    .result_o (result)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_q.irq, out_q.rdata};

endmodule

`default_nettype wire
